// ----- hw/rtl/dsv_pkg.sv -----
// ----------------------------------------------------------------------------
// dsv_pkg
// Shared types, character codes, status codes and the month length table of
// the date string validator.
// ----------------------------------------------------------------------------
package dsv_pkg;

   localparam int unsigned CharWidth   = 8;
   localparam int unsigned DayWidth    = 7;
   localparam int unsigned MonthWidth  = 7;
   localparam int unsigned YearWidth   = 14;
   localparam int unsigned StatusWidth = 3;

   localparam logic [CharWidth-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [CharWidth-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CharWidth-1:0] CHAR_NINE  = 8'h39;

   localparam logic [DayWidth-1:0]   DAY_MAX   = 7'd127;
   localparam logic [MonthWidth-1:0] MONTH_MAX = 7'd127;
   localparam logic [YearWidth-1:0]  YEAR_MAX  = 14'd16383;
   localparam logic [YearWidth-1:0]  YEAR_LIMIT   = 14'd9999;
   localparam logic [MonthWidth-1:0] MONTH_LIMIT  = 7'd12;
   localparam logic [MonthWidth-1:0] MONTH_FEB    = 7'd2;
   localparam logic [DayWidth-1:0]   DAY_LEAP_FEB = 7'd29;

   // Field indexes in field_seen
   localparam int unsigned FIELD_DAY   = 0;
   localparam int unsigned FIELD_MONTH = 1;
   localparam int unsigned FIELD_YEAR  = 2;

   localparam logic [StatusWidth-1:0] STATUS_VALID       = 3'd0;
   localparam logic [StatusWidth-1:0] STATUS_FEW_SLASH   = 3'd1;
   localparam logic [StatusWidth-1:0] STATUS_BAD_CHAR    = 3'd2;
   localparam logic [StatusWidth-1:0] STATUS_MANY_SLASH  = 3'd3;
   localparam logic [StatusWidth-1:0] STATUS_EMPTY_FIELD = 3'd4;
   localparam logic [StatusWidth-1:0] STATUS_BAD_YEAR    = 3'd5;
   localparam logic [StatusWidth-1:0] STATUS_BAD_MONTH   = 3'd6;
   localparam logic [StatusWidth-1:0] STATUS_BAD_DAY     = 3'd7;

   // Accumulated parse state. The last two decimal digits of the year and the
   // hundreds part mod 4 are kept beside the value, so the leap test needs
   // no division.
   typedef struct packed {
      logic [1:0]            slash_count;
      logic [DayWidth-1:0]   day_value;
      logic [MonthWidth-1:0] month_value;
      logic [YearWidth-1:0]  year_value;
      logic [3:0]            year_tens;
      logic [3:0]            year_ones;
      logic [1:0]            year_hund_mod4;
      logic [2:0]            field_seen;
      logic                  bad_char_seen;
   } acc_type;

   function automatic logic [DayWidth-1:0] month_len(input logic [3:0] month);
      logic [DayWidth-1:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 7'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 7'd30;
         4'd2:                                       len = 7'd28;
         default:                                    len = 7'd0;
      endcase
      return len;
   endfunction

endpackage

// ----- hw/rtl/dsv_field_acc.sv -----
// ----------------------------------------------------------------------------
// dsv_field_acc
// Parse state of the date text: slash count, saturating field values, field
// presence and bad character flag. Shows the state after the current beat.
// ----------------------------------------------------------------------------
module dsv_field_acc
   import dsv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_valid,
   input  logic [CharWidth-1:0] step_char,
   input  logic                 step_last,
   output acc_type              acc_next
);

   acc_type acc_ff;
   acc_type acc_in;

   logic         is_slash;
   logic         is_digit;
   logic [3:0]   digit;
   logic [1:0]   field_idx;
   logic [10:0]  day_push;
   logic [10:0]  month_push;
   logic [17:0]  year_push;

   always_comb begin
      is_slash  = (step_char == CHAR_SLASH);
      is_digit  = (step_char >= CHAR_ZERO) && (step_char <= CHAR_NINE);
      digit     = step_char[3:0];
      field_idx = acc_ff.slash_count[1] ? 2'd2 : acc_ff.slash_count;

      day_push   = {1'b0, acc_ff.day_value, 3'b000} + {3'b000, acc_ff.day_value, 1'b0}
                 + {7'd0, digit};
      month_push = {1'b0, acc_ff.month_value, 3'b000} + {3'b000, acc_ff.month_value, 1'b0}
                 + {7'd0, digit};
      year_push  = {1'b0, acc_ff.year_value, 3'b000} + {3'b000, acc_ff.year_value, 1'b0}
                 + {14'd0, digit};

      acc_next = acc_ff;
      if (is_slash) begin
         if (acc_ff.slash_count != 2'd3) begin
            acc_next.slash_count = acc_ff.slash_count + 2'd1;
         end
      end else begin
         acc_next.field_seen[field_idx] = 1'b1;
         if (!is_digit) begin
            acc_next.bad_char_seen = 1'b1;
         end else if (field_idx == 2'd0) begin
            acc_next.day_value = (day_push > {4'd0, DAY_MAX}) ? DAY_MAX
                               : day_push[DayWidth-1:0];
         end else if (field_idx == 2'd1) begin
            acc_next.month_value = (month_push > {4'd0, MONTH_MAX}) ? MONTH_MAX
                                 : month_push[MonthWidth-1:0];
         end else begin
            acc_next.year_value = (year_push > {4'd0, YEAR_MAX}) ? YEAR_MAX
                                : year_push[YearWidth-1:0];
            // hundreds mod 4 advances as (10 * h + tens) mod 4
            acc_next.year_hund_mod4 = {acc_ff.year_hund_mod4[0], 1'b0}
                                    + acc_ff.year_tens[1:0];
            acc_next.year_tens = acc_ff.year_ones;
            acc_next.year_ones = digit;
         end
      end

      acc_in = acc_ff;
      if (step_valid) begin
         acc_in = step_last ? '0 : acc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

`ifndef SYNTHESIS
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (step_valid && step_last) |=> (acc_ff == '0))
      else $error("parse state not cleared after last beat");

   a_month_needs_slash: assert property (@(posedge clock) disable iff (reset)
      acc_ff.field_seen[FIELD_MONTH] |-> (acc_ff.slash_count != 2'd0))
      else $error("month field seen before first slash");

   a_year_needs_slashes: assert property (@(posedge clock) disable iff (reset)
      acc_ff.field_seen[FIELD_YEAR] |-> acc_ff.slash_count[1])
      else $error("year field seen before second slash");
`endif

endmodule

// ----- hw/rtl/dsv_status.sv -----
// ----------------------------------------------------------------------------
// dsv_status
// Priority check of a finished parse state into one status code.
// ----------------------------------------------------------------------------
module dsv_status
   import dsv_pkg::*;
(
   input  acc_type                acc,
   output logic [StatusWidth-1:0] status
);

   logic                is_leap;
   logic                div100;
   logic [DayWidth-1:0] day_limit;

   always_comb begin
      div100  = (acc.year_tens == 4'd0) && (acc.year_ones == 4'd0);
      is_leap = (div100 && (acc.year_hund_mod4 == 2'd0))
             || ((acc.year_value[1:0] == 2'b00) && !div100);

      day_limit = month_len(acc.month_value[3:0]);
      if ((acc.month_value == MONTH_FEB) && is_leap) begin
         day_limit = DAY_LEAP_FEB;
      end

      if (!acc.slash_count[1]) begin
         status = STATUS_FEW_SLASH;
      end else if (acc.bad_char_seen) begin
         status = STATUS_BAD_CHAR;
      end else if (acc.slash_count == 2'd3) begin
         status = STATUS_MANY_SLASH;
      end else if (acc.field_seen != 3'b111) begin
         status = STATUS_EMPTY_FIELD;
      end else if (acc.year_value > YEAR_LIMIT) begin
         status = STATUS_BAD_YEAR;
      end else if ((acc.month_value == '0) || (acc.month_value > MONTH_LIMIT)) begin
         status = STATUS_BAD_MONTH;
      end else if ((acc.day_value == '0) || (acc.day_value > day_limit)) begin
         status = STATUS_BAD_DAY;
      end else begin
         status = STATUS_VALID;
      end
   end

endmodule

// ----- hw/rtl/date_string_validator_top.sv -----
// ----------------------------------------------------------------------------
// date_string_validator_top
// Stream checker for dd/mm/yyyy date text, one character per beat.
// ----------------------------------------------------------------------------
// Feed the date text one ASCII character per beat on the req_ stream and mark
// the final character with req_tlast. The block takes one beat every cycle
// unless a held response stalls it: a character is captured in an input
// register, then folded into the parse state (slash count, saturating day,
// month and year values, field presence, bad character flag), and on the
// last beat the status is checked and loaded into the rsp_ output register
// at the same edge that folds that character. Only the last beat produces
// a response; the parse state clears right after it, so the next date can
// follow without a gap. Status codes, checked in this order: 1 fewer than
// two slashes, 2 bad character, 3 more than two slashes, 4 empty field, 5
// year over 9999, 6 month outside 1..12, 7 day outside the month's length
// (February has 29 days in leap years), 0 valid. A held response stalls the
// input only when a further last beat reaches the parse stage.
module date_string_validator_top
   import dsv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_char
   input  logic       req_tlast,   // end_of_text
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [2:0] date_status, [3] date_ok, [7:4] zero
);

   // Input register
   logic                 in_valid_ff, in_valid_in;
   logic [CharWidth-1:0] in_char_ff,  in_char_in;
   logic                 in_last_ff,  in_last_in;

   // Output register
   logic                   rsp_valid_ff,  rsp_valid_in;
   logic [StatusWidth-1:0] rsp_status_ff, rsp_status_in;
   logic                   rsp_ok_ff,     rsp_ok_in;

   logic                   advance;
   acc_type                acc_next;
   logic [StatusWidth-1:0] status;

   // Advance the captured beat unless it needs the output slot and that slot
   // is still held by the consumer.
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   dsv_field_acc u_field_acc (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .step_char  (in_char_ff),
      .step_last  (in_last_ff),
      .acc_next   (acc_next)
   );

   dsv_status u_status (
      .acc    (acc_next),
      .status (status)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_last_in  = in_last_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_char_in  = req_tdata;
         in_last_in  = req_tlast;
      end

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_ok_in     = rsp_ok_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         rsp_ok_in     = (status == STATUS_VALID);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_char_ff    <= in_char_in;
      in_last_ff    <= in_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ok_ff     <= rsp_ok_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ok_ff, rsp_status_ff};

`ifndef SYNTHESIS
   a_ok_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ok_ff == (rsp_status_ff == STATUS_VALID)))
      else $error("date_ok disagrees with date_status");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && in_last_ff))
      else $error("response raised without a last beat");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> ($stable(rsp_status_ff) && $stable(rsp_ok_ff)))
      else $error("held response overwritten");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date string validator testbench
// Streams dd/mm/yyyy text into the validator one character per beat and checks
// every status beat against a cycle-free parser kept alongside. A short table
// of hand-picked dates runs first: calendar edges, leap years and every status
// code. Mostly well-formed random dates follow, mixed with damaged dates and
// raw byte noise. The sender works in bursts and the receiver stalls in modes.
// ----------------------------------------------------------------------------
module testbench
   import dsv_pkg::*;
();

   localparam int TotalBeats = 1200;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic                   ok;
   } verdict_type;

   // One row of the directed table. Rows with pinned set carry a status that
   // can be read straight off the date; the rest take the parser's verdict.
   typedef struct {
      string                  text;
      bit                     pinned;
      logic [StatusWidth-1:0] status;
   } date_case_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] text_char
   logic       req_tlast = 1'b0;    // end_of_text
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [2:0] date_status, [3] date_ok, [7:4] zero

   // Parser state, mirrors what the block accumulates between end marks
   logic [1:0]            seen_slashes;
   logic [DayWidth-1:0]   day_acc;
   logic [MonthWidth-1:0] month_acc;
   logic [YearWidth-1:0]  year_acc;
   logic [2:0]            fields_hit;
   logic                  bad_char_hit;

   verdict_type   pending_verdicts[$];
   date_case_type date_table[$];
   logic [7:0] date_text[$];        // characters of the date being sent
   bit         pin_on;
   logic [StatusWidth-1:0] pin_status;

   int mismatches = 0;
   int burst_left;
   int beats_sent;
   int rdy_left = 0;
   int rdy_mode;

   date_string_validator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // Parser
   // -------------------------------------------------------------------------
   function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
      int unsigned n;
      case (m)
         2:           n = ((y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0))) ? 29 : 28;
         4, 6, 9, 11: n = 30;
         default:     n = 31;
      endcase
      return n;
   endfunction

   function automatic logic [StatusWidth-1:0] date_verdict();
      logic [StatusWidth-1:0] s;
      if (seen_slashes < 2)
         s = STATUS_FEW_SLASH;
      else if (bad_char_hit)
         s = STATUS_BAD_CHAR;
      else if (seen_slashes > 2)
         s = STATUS_MANY_SLASH;
      else if (fields_hit != 3'b111)
         s = STATUS_EMPTY_FIELD;
      else if (year_acc > 9999)
         s = STATUS_BAD_YEAR;
      else if (month_acc < 1 || month_acc > 12)
         s = STATUS_BAD_MONTH;
      else if (day_acc < 1 || day_acc > days_in_month(month_acc, year_acc))
         s = STATUS_BAD_DAY;
      else
         s = STATUS_VALID;
      return s;
   endfunction

   function automatic int unsigned sat_push(input int unsigned v, input int unsigned d,
                                            input int unsigned top);
      int unsigned n;
      n = v * 10 + d;
      return (n > top) ? top : n;
   endfunction

   task automatic clear_parser();
      seen_slashes = '0;
      day_acc      = '0;
      month_acc    = '0;
      year_acc     = '0;
      fields_hit   = '0;
      bad_char_hit = 1'b0;
   endtask

   // Fold one accepted character into the parser; on the end mark, queue the
   // status the block owes and start over.
   task automatic fold_char(input logic [7:0] ch, input bit last);
      int unsigned fld;
      logic [StatusWidth-1:0] s;
      if (ch == CHAR_SLASH) begin
         if (seen_slashes != 2'd3) seen_slashes = seen_slashes + 2'd1;
      end else begin
         fld = (seen_slashes >= 2) ? 2 : seen_slashes;
         fields_hit[fld] = 1'b1;
         if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            case (fld)
               0:       day_acc   = DayWidth'(sat_push(day_acc, ch - CHAR_ZERO, 127));
               1:       month_acc = MonthWidth'(sat_push(month_acc, ch - CHAR_ZERO, 127));
               default: year_acc  = YearWidth'(sat_push(year_acc, ch - CHAR_ZERO, 16383));
            endcase
         end else begin
            bad_char_hit = 1'b1;
         end
      end
      if (last) begin
         s = pin_on ? pin_status : date_verdict();
         pending_verdicts.push_back('{status: s, ok: (s == STATUS_VALID)});
         clear_parser();
      end
   endtask

   // -------------------------------------------------------------------------
   // Sender
   // -------------------------------------------------------------------------
   task automatic hold_off(input int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Present one beat and hold it until the block takes it
   task automatic send_beat(input logic [7:0] ch, input bit last);
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      fold_char(ch, last);
      beats_sent++;
   endtask

   // Send the queued text with the end mark on its final character. Bursts of
   // random length alternate with random gaps; some bursts run long with none.
   task automatic send_text();
      for (int i = 0; i < date_text.size(); i++) begin
         if (burst_left == 0) begin
            hold_off($urandom_range(0, 5));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
         end
         burst_left--;
         send_beat(date_text[i], i == date_text.size() - 1);
      end
      date_text.delete();
   endtask

   task automatic drain_verdicts();
      hold_off(1);
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Random dates
   // -------------------------------------------------------------------------
   task automatic put_number(input int unsigned v, input int unsigned min_digits);
      logic [7:0] digits[$];
      int unsigned r;
      r = v;
      do begin
         digits.push_front(8'(CHAR_ZERO + r % 10));
         r = r / 10;
      end while (r != 0);
      while (digits.size() < min_digits) digits.push_front(CHAR_ZERO);
      foreach (digits[k]) date_text.push_back(digits[k]);
   endtask

   task automatic build_good_date();
      int unsigned y, m, d, lim, pad;
      case ($urandom_range(0, 9))
         0:       y = 0;
         1:       y = 100 * $urandom_range(0, 99);   // century years test the leap rule
         2:       y = 4 * $urandom_range(0, 2499);
         3:       y = $urandom_range(10000, 99999);  // over the limit or saturating
         4:       y = 9999;
         default: y = $urandom_range(0, 9999);
      endcase
      m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
      lim = (m >= 1 && m <= 12) ? days_in_month(m, y) : 31;
      case ($urandom_range(0, 5))
         0:       d = lim + $urandom_range(0, 1);    // last day of the month or one past
         1:       d = ($urandom_range(0, 3) == 0) ? 0 : 1;
         2:       d = (m == 2) ? 29 : $urandom_range(28, 31);
         3:       d = $urandom_range(0, 999);
         default: d = $urandom_range(1, 31);
      endcase
      pad = ($urandom_range(0, 2) != 0) ? 1 : 0;
      put_number(d, pad ? 2 : 1);
      date_text.push_back(CHAR_SLASH);
      put_number(m, pad ? 2 : 1);
      date_text.push_back(CHAR_SLASH);
      put_number(y, pad ? 4 : 1);
   endtask

   task automatic build_random_date();
      int unsigned kind, len, pos;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         build_good_date();
      end else if (kind < 85) begin
         build_good_date();
         pos = $urandom_range(0, date_text.size() - 1);
         case ($urandom_range(0, 3))
            0: date_text[pos] = 8'($urandom_range(0, 255));
            1: date_text.insert(pos, CHAR_SLASH);
            2: date_text.delete(pos);
            default: begin
               // drop every non-slash character up to the chosen position
               for (int k = date_text.size() - 1; k >= 0; k--)
                  if (date_text[k] != CHAR_SLASH && k <= pos) date_text.delete(k);
            end
         endcase
         if (date_text.size() == 0) date_text.push_back(CHAR_SLASH);
      end else begin
         len = $urandom_range(1, 12);
         repeat (len) begin
            case ($urandom_range(0, 2))
               0:       date_text.push_back(CHAR_SLASH);
               1:       date_text.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
               default: date_text.push_back(8'($urandom_range(0, 255)));
            endcase
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Receiver: stall in modes of random length (always ready, coin flip,
   // mostly stalled)
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rdy_left == 0) begin
         rdy_mode = $urandom_range(0, 2);
         rdy_left = $urandom_range(8, 64);
      end else begin
         rdy_left--;
      end
      case (rdy_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // -------------------------------------------------------------------------
   // Status checker: compare each taken status beat with the oldest verdict
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: status beat %0d with no date pending", $realtime, rsp_tdata[2:0]);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tdata[2:0] !== want.status || rsp_tdata[3] !== want.ok) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: status mismatch: expected status %0d ok %0b, got status %0d ok %0b",
                           $realtime, want.status, want.ok, rsp_tdata[2:0], rsp_tdata[3]);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Directed table
   // -------------------------------------------------------------------------
   task automatic add_case(input string text, input bit pinned,
                           input logic [StatusWidth-1:0] status);
      date_table.push_back('{text: text, pinned: pinned, status: status});
   endtask

   initial begin
      add_case("01/01/2000",     1'b1, STATUS_VALID);
      add_case("31/12/9999",     1'b1, STATUS_VALID);
      add_case("29/02/2000",     1'b1, STATUS_VALID);        // divisible by 400
      add_case("29/02/1900",     1'b1, STATUS_BAD_DAY);      // century, not leap
      add_case("29/02/2024",     1'b1, STATUS_VALID);
      add_case("29/02/2023",     1'b1, STATUS_BAD_DAY);
      add_case("29/02/0",        1'b1, STATUS_VALID);        // year zero is leap
      add_case("00/01/2000",     1'b1, STATUS_BAD_DAY);
      add_case("31/04/2021",     1'b1, STATUS_BAD_DAY);
      add_case("01/00/2000",     1'b1, STATUS_BAD_MONTH);
      add_case("01/13/2000",     1'b1, STATUS_BAD_MONTH);
      add_case("01/01/10000",    1'b1, STATUS_BAD_YEAR);
      add_case("999/999/999999", 1'b0, STATUS_VALID);        // every value saturates
      add_case("1/1",            1'b1, STATUS_FEW_SLASH);
      add_case("/",              1'b1, STATUS_FEW_SLASH);
      add_case("ab",             1'b1, STATUS_FEW_SLASH);    // slash count outranks bad char
      add_case("0a/01/2000",     1'b1, STATUS_BAD_CHAR);
      add_case("01/01/20/00",    1'b1, STATUS_MANY_SLASH);
      add_case("x/1/2/3",        1'b1, STATUS_BAD_CHAR);     // bad char outranks extra slash
      add_case("01/02//2000",    1'b1, STATUS_MANY_SLASH);
      add_case("//2000",         1'b1, STATUS_EMPTY_FIELD);
      add_case("01/01/",         1'b1, STATUS_EMPTY_FIELD);
      add_case("\377\200/ /\001", 1'b1, STATUS_BAD_CHAR);   // bad chars still fill fields
      add_case("1/1/1",          1'b1, STATUS_VALID);
      add_case("30/11/0099",     1'b0, STATUS_VALID);
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      bit drained;
      burst_left = 0;
      beats_sent = 0;
      pin_on     = 1'b0;
      pin_status = STATUS_VALID;
      drained    = 1'b0;
      clear_parser();

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table, one date per row
      foreach (date_table[r]) begin
         for (int i = 0; i < date_table[r].text.len(); i++)
            date_text.push_back(date_table[r].text[i]);
         pin_on     = date_table[r].pinned;
         pin_status = date_table[r].status;
         send_text();
      end
      pin_on = 1'b0;

      // Random dates; pause once mid-run until every status is back
      while (beats_sent < TotalBeats) begin
         if (!drained && beats_sent >= TotalBeats / 2) begin
            drain_verdicts();
            drained = 1'b1;
         end
         build_random_date();
         send_text();
      end

      // Let the last statuses come out, then a few spare cycles
      drain_verdicts();
      repeat (20) @(posedge clock);

      if (mismatches == 0 && pending_verdicts.size() == 0)
         $display("[date_string_validator_top] OK");
      else
         $display("[date_string_validator_top] ERROR");
      $finish;
   end

   // Watchdog
   initial begin
      #5ms;
      $display("[date_string_validator_top] ERROR");
      $finish;
   end

endmodule
